[rtl/ps2kc_pkg.sv]
// ps2kc_pkg: shared types, codes and the scan code table for the keyboard controller
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ps2kc_pkg;

  localparam int RAM_BYTES = 32;
  localparam int RAM_AW    = $clog2(RAM_BYTES);

  // item kinds
  localparam logic [2:0] ITEM_RD_DATA = 3'd0;
  localparam logic [2:0] ITEM_RD_STAT = 3'd1;
  localparam logic [2:0] ITEM_WR_DATA = 3'd2;
  localparam logic [2:0] ITEM_WR_CMD  = 3'd3;
  localparam logic [2:0] ITEM_KBD     = 3'd4;
  localparam logic [2:0] ITEM_AUX     = 3'd5;

  // controller ram locations
  localparam logic [RAM_AW-1:0] LOC_CMD     = 5'h00;
  localparam logic [RAM_AW-1:0] LOC_STAT    = 5'h01;
  localparam logic [RAM_AW-1:0] LOC_OBUF    = 5'h02;
  localparam logic [RAM_AW-1:0] LOC_LASTCMD = 5'h03;
  localparam logic [RAM_AW-1:0] LOC_RELEASE = 5'h04;
  localparam logic [RAM_AW-1:0] LOC_OUTPORT = 5'h05;
  localparam logic [RAM_AW-1:0] LOC_PWLEN   = 5'h06;
  localparam logic [RAM_AW-1:0] LOC_PWIDX   = 5'h07;
  localparam logic [RAM_AW-1:0] LOC_PWBASE  = 5'h08;
  localparam logic [RAM_AW-1:0] LOC_SEC_ON  = 5'h13;
  localparam logic [RAM_AW-1:0] LOC_SEC_OFF = 5'h14;
  localparam logic [RAM_AW-1:0] LOC_IGN0    = 5'h16;
  localparam logic [RAM_AW-1:0] LOC_IGN1    = 5'h17;
  localparam logic [RAM_AW-1:0] LOC_DEVLOCK = 5'h18;

  // controller commands
  localparam logic [7:0] KC_PW_CHECK  = 8'ha4;
  localparam logic [7:0] KC_PW_LOAD   = 8'ha5;
  localparam logic [7:0] KC_PW_ENABLE = 8'ha6;
  localparam logic [7:0] KC_AUX_DIS   = 8'ha7;
  localparam logic [7:0] KC_AUX_EN    = 8'ha8;
  localparam logic [7:0] KC_AUX_TEST  = 8'ha9;
  localparam logic [7:0] KC_SELF_TEST = 8'haa;
  localparam logic [7:0] KC_KBD_TEST  = 8'hab;
  localparam logic [7:0] KC_KBD_DIS   = 8'had;
  localparam logic [7:0] KC_KBD_EN    = 8'hae;
  localparam logic [7:0] KC_RD_INPORT = 8'hc0;
  localparam logic [7:0] KC_RD_OUTP   = 8'hd0;
  localparam logic [7:0] KC_WR_OUTP   = 8'hd1;
  localparam logic [7:0] KC_WR_KBDBUF = 8'hd2;
  localparam logic [7:0] KC_WR_AUXBUF = 8'hd3;
  localparam logic [7:0] KC_WR_AUX    = 8'hd4;
  localparam logic [7:0] KC_A20_OFF   = 8'hdd;
  localparam logic [7:0] KC_A20_ON    = 8'hdf;
  localparam logic [7:0] KC_RD_TEST   = 8'he0;

  localparam logic [7:0] BYTE_RELEASE = 8'hf0;
  localparam logic [7:0] BYTE_ACK     = 8'hfa;
  localparam logic [7:0] BYTE_NOPW    = 8'hf1;
  localparam logic [7:0] BYTE_TEST_OK = 8'h55;

  typedef struct packed {
    logic [7:0] read_value;
    logic       device_byte_taken;
    logic       irq_keyboard;
    logic       irq_aux;
    logic       a20_update;
    logic       a20_level;
    logic       system_reset;
    logic       send_to_keyboard;
    logic       send_to_aux;
    logic [7:0] forward_byte;
  } result_t;

  typedef logic [RAM_BYTES-1:0][7:0] ram_t;

  localparam logic [7:0] SC2TO1 [128] = '{
    8'hff,8'h43,8'h41,8'h3f,8'h3d,8'h3b,8'h3c,8'h58,8'h64,8'h44,8'h42,8'h40,8'h3e,8'h0f,8'h29,8'h59,
    8'h65,8'h38,8'h2a,8'h70,8'h1d,8'h10,8'h02,8'h5a,8'h66,8'h71,8'h2c,8'h1f,8'h1e,8'h11,8'h03,8'h5b,
    8'h67,8'h2e,8'h2d,8'h20,8'h12,8'h05,8'h04,8'h5c,8'h68,8'h39,8'h2f,8'h21,8'h14,8'h13,8'h06,8'h5d,
    8'h69,8'h31,8'h30,8'h23,8'h22,8'h15,8'h07,8'h5e,8'h6a,8'h72,8'h32,8'h24,8'h16,8'h08,8'h09,8'h5f,
    8'h6b,8'h33,8'h25,8'h17,8'h18,8'h0b,8'h0a,8'h60,8'h6c,8'h34,8'h35,8'h26,8'h27,8'h19,8'h0c,8'h61,
    8'h6d,8'h73,8'h28,8'h74,8'h1a,8'h0d,8'h62,8'h6e,8'h3a,8'h36,8'h1c,8'h1b,8'h75,8'h2b,8'h63,8'h76,
    8'h55,8'h56,8'h77,8'h78,8'h79,8'h7a,8'h0e,8'h7b,8'h7c,8'h4f,8'h7d,8'h4b,8'h47,8'h7e,8'h7f,8'h6f,
    8'h52,8'h53,8'h50,8'h4c,8'h4d,8'h48,8'h01,8'h45,8'h57,8'h4e,8'h51,8'h4a,8'h37,8'h49,8'h46,8'h54
  };

  function automatic logic [7:0] map_set2(input logic [7:0] v);
    logic [7:0] r;
    if (!v[7]) r = SC2TO1[v[6:0]];
    else if (v == 8'h83) r = 8'h41;
    else if (v == 8'h84) r = 8'h54;
    else r = v;
    return r;
  endfunction

  function automatic ram_t ram_reset_value();
    ram_t r;
    r = '0;
    r[LOC_CMD] = 8'h41;
    r[LOC_STAT] = 8'h10;
    r[LOC_OUTPORT] = 8'h03;
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/ps2kc_engine.sv]
// ps2kc_engine: controller ram and the per-word decision logic
// depends on ps2kc_pkg
`timescale 1ns / 1ps
`default_nettype none
module ps2kc_engine (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [2:0]        item_cmd,
  input  wire logic [7:0]        item_byte,
  output ps2kc_pkg::result_t     res
);
  import ps2kc_pkg::*;

  ram_t ram;
  ram_t ram_next;

  always_comb begin
    logic       dreq;
    logic       daux;
    logic [7:0] dv;
    logic       handled;
    logic       swallowed;
    logic [7:0] lc;
    logic [7:0] n;
    logic [7:0] idx;
    logic [7:0] nidx;
    logic [7:0] st;
    logic [7:0] dis;

    ram_next = ram;
    res = '0;
    dreq = 1'b0;
    daux = 1'b0;
    dv = '0;
    handled = 1'b0;
    swallowed = 1'b0;
    lc = ram[LOC_LASTCMD];
    n = ram[LOC_PWLEN];
    idx = '0;
    nidx = '0;
    st = '0;
    dis = (item_cmd == ITEM_AUX) ? 8'h20 : 8'h10;

    unique case (item_cmd)
      ITEM_RD_DATA: begin
        res.read_value = ram[LOC_OBUF];
        ram_next[LOC_STAT] = ram[LOC_STAT] & ~8'h21;
        ram_next[LOC_OUTPORT] = ram[LOC_OUTPORT] & ~8'h30;
      end
      ITEM_RD_STAT: begin
        res.read_value = (ram[LOC_STAT] & ~8'h04) | (ram[LOC_CMD] & 8'h04);
      end
      ITEM_WR_DATA: begin
        if (ram[LOC_STAT][4]) begin
          if (ram[LOC_STAT][3]) begin
            handled = 1'b1;
            if (lc >= 8'h60 && lc <= 8'h7f) begin
              ram_next[lc[RAM_AW-1:0]] = item_byte;
            end else if (lc == KC_PW_LOAD) begin
              if (n <= 8'd6) begin
                ram_next[LOC_PWBASE + {2'b00, n[2:0]}] = item_byte;
                ram_next[LOC_PWLEN] = (item_byte != 8'd0) ? n + 8'd1 : 8'd15;
              end
            end else if (lc == KC_WR_OUTP) begin
              ram_next[LOC_OUTPORT] = item_byte;
              res.a20_update = 1'b1;
              res.a20_level = item_byte[1];
              res.system_reset = !item_byte[0];
            end else if (lc == KC_WR_KBDBUF) begin
              // optional set 2 to set 1 translation
              if (ram[LOC_CMD][6]) begin
                if (item_byte == BYTE_RELEASE) begin
                  ram_next[LOC_RELEASE] = 8'd1;
                  dv = item_byte;
                end else begin
                  dv = map_set2(item_byte);
                  if (ram[LOC_RELEASE] != 8'd0) dv = dv | 8'h80;
                  ram_next[LOC_RELEASE] = 8'd0;
                end
              end else begin
                dv = item_byte;
                ram_next[LOC_RELEASE] = 8'd0;
              end
              dreq = 1'b1;
            end else if (lc == KC_WR_AUXBUF) begin
              dreq = 1'b1;
              daux = 1'b1;
              dv = item_byte;
            end else if (lc == KC_WR_AUX) begin
              res.send_to_aux = 1'b1;
              res.forward_byte = item_byte;
            end else if (lc == KC_A20_OFF) begin
              ram_next[LOC_OUTPORT] = ram[LOC_OUTPORT] & ~8'h02;
              res.a20_update = 1'b1;
              res.a20_level = 1'b0;
            end else if (lc == KC_A20_ON) begin
              ram_next[LOC_OUTPORT] = ram[LOC_OUTPORT] | 8'h02;
              res.a20_update = 1'b1;
              res.a20_level = 1'b1;
            end else begin
              handled = 1'b0;
            end
          end
          ram_next[LOC_STAT][3] = 1'b0;
          if (!handled) begin
            res.send_to_keyboard = 1'b1;
            res.forward_byte = item_byte;
          end
        end
      end
      ITEM_WR_CMD: begin
        if (ram[LOC_STAT][4]) begin
          ram_next[LOC_LASTCMD] = item_byte;
          ram_next[LOC_STAT][3] = 1'b1;
          if (item_byte >= 8'h20 && item_byte <= 8'h3f) begin
            // reads see the command byte just latched
            dreq = 1'b1;
            dv = ram_next[item_byte[RAM_AW-1:0]];
          end else if (item_byte >= 8'hf0) begin
            res.system_reset = !item_byte[0];
          end else begin
            case (item_byte)
              KC_PW_CHECK: begin
                dreq = 1'b1;
                dv = (ram[LOC_PWLEN] != 8'd0) ? BYTE_ACK : BYTE_NOPW;
              end
              KC_PW_ENABLE: begin
                ram_next[LOC_STAT][4] = 1'b0;
                ram_next[LOC_PWIDX] = 8'd0;
                if (ram[LOC_SEC_ON] != 8'd0) begin
                  ram_next[LOC_OBUF] = ram[LOC_SEC_ON];
                  ram_next[LOC_STAT][5] = 1'b0;
                  ram_next[LOC_STAT][0] = 1'b1;
                  res.irq_keyboard = ram[LOC_CMD][0];
                end
              end
              KC_AUX_DIS:   ram_next[LOC_CMD][5] = 1'b1;
              KC_AUX_EN:    ram_next[LOC_CMD][5] = 1'b0;
              KC_SELF_TEST: begin
                dreq = 1'b1;
                dv = BYTE_TEST_OK;
              end
              KC_AUX_TEST, KC_KBD_TEST, KC_RD_INPORT, KC_RD_TEST: begin
                dreq = 1'b1;
                dv = 8'd0;
              end
              KC_KBD_DIS:   ram_next[LOC_CMD][4] = 1'b1;
              KC_KBD_EN:    ram_next[LOC_CMD][4] = 1'b0;
              KC_RD_OUTP: begin
                dreq = 1'b1;
                dv = ram[LOC_OUTPORT];
              end
              default: ;
            endcase
          end
        end
      end
      ITEM_KBD, ITEM_AUX: begin
        if (ram[LOC_DEVLOCK] == 8'd0 && (ram[LOC_CMD] & dis) == 8'd0 && !ram[LOC_STAT][0]) begin
          res.device_byte_taken = 1'b1;
          if (item_cmd == ITEM_AUX) begin
            dreq = 1'b1;
            daux = 1'b1;
            dv = item_byte;
          end else if (ram[LOC_CMD][6]) begin
            if (item_byte == BYTE_RELEASE) begin
              // release prefix only arms the flag
              ram_next[LOC_RELEASE] = 8'd1;
            end else begin
              dv = map_set2(item_byte);
              if (ram[LOC_RELEASE] != 8'd0) dv = dv | 8'h80;
              ram_next[LOC_RELEASE] = 8'd0;
              dreq = 1'b1;
            end
          end else begin
            ram_next[LOC_RELEASE] = 8'd0;
            dv = item_byte;
            dreq = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // delivery to the output buffer, through the password lock
    if (dreq) begin
      if (!ram_next[LOC_STAT][4]) begin
        swallowed = 1'b1;
        if (!(dv[7] || dv == ram_next[LOC_IGN0] || dv == ram_next[LOC_IGN1] || daux)) begin
          idx = ram_next[LOC_PWIDX];
          nidx = (dv == ram_next[LOC_PWBASE + idx[RAM_AW-1:0]]) ? idx + 8'd1 : 8'd0;
          ram_next[LOC_PWIDX] = nidx;
          if (nidx > 8'd6 || ram_next[LOC_PWBASE + nidx[RAM_AW-1:0]] == 8'd0) begin
            ram_next[LOC_STAT][4] = 1'b1;
            if (ram_next[LOC_SEC_OFF] != 8'd0) begin
              dv = ram_next[LOC_SEC_OFF];
              swallowed = 1'b0;
            end
          end
        end
      end
      if (!swallowed) begin
        ram_next[LOC_OBUF] = dv;
        st = (ram_next[LOC_STAT] & ~8'h21) | (daux ? 8'h21 : 8'h01);
        ram_next[LOC_STAT] = st;
        if (daux && ram_next[LOC_CMD][1]) begin
          ram_next[LOC_OUTPORT][5] = 1'b1;
          res.irq_aux = 1'b1;
        end else if (!daux && ram_next[LOC_CMD][0]) begin
          ram_next[LOC_OUTPORT][4] = 1'b1;
          res.irq_keyboard = 1'b1;
        end
      end
    end

    if (res.system_reset) ram_next = ram_reset_value();
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram <= ram_reset_value();
    end else if (step) begin
      ram <= ram_next;
    end
  end

endmodule
`default_nettype wire

[rtl/ps2_keyboard_controller.sv]
// ps2_keyboard_controller: top level with input and result registers
// depends on ps2kc_pkg and ps2kc_engine
`timescale 1ns / 1ps
`default_nettype none
// 8042-style keyboard controller.
// Input channel (in_valid/in_ready): one word per host port access or
// device byte, command selects the kind, data_byte carries the byte.
// Output channel (out_valid/out_ready): exactly one result word per input
// word, in order: read data, device acceptance, irq pulses, A20 report,
// reset request and a byte to forward to a device.
// A word is captured in the input register, decided against the controller
// ram once the result register is free or being read, and its result then
// lands in the result register.
// Throughput: one word per cycle while out_ready does not stall the output;
// the only loop is the controller ram update, done once per word.
// Reset: the controller ram returns to command byte 0x41, status 0x10,
// output port 0x03, everything else zero; both registers empty.
// A requested machine reset restores the same ram contents.
// Stall: while out_ready is low the result register holds, one more word
// waits in the input register and then in_ready drops.
module ps2_keyboard_controller (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] command,
  input  wire logic [7:0] data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      read_value,
  output logic            device_byte_taken,
  output logic            irq_keyboard,
  output logic            irq_aux,
  output logic            a20_update,
  output logic            a20_level,
  output logic            system_reset,
  output logic            send_to_keyboard,
  output logic            send_to_aux,
  output logic [7:0]      forward_byte
);
  import ps2kc_pkg::*;

  logic       in_full;
  logic [2:0] cmd_r;
  logic [7:0] byte_r;
  logic       step;
  result_t    res;
  result_t    res_r;

  assign step = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || step;

  ps2kc_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item_cmd  (cmd_r),
    .item_byte (byte_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) in_full <= in_valid;
      if (step) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= command;
      byte_r <= data_byte;
    end
    if (step) res_r <= res;
  end

  assign read_value        = res_r.read_value;
  assign device_byte_taken = res_r.device_byte_taken;
  assign irq_keyboard      = res_r.irq_keyboard;
  assign irq_aux           = res_r.irq_aux;
  assign a20_update        = res_r.a20_update;
  assign a20_level         = res_r.a20_level;
  assign system_reset      = res_r.system_reset;
  assign send_to_keyboard  = res_r.send_to_keyboard;
  assign send_to_aux       = res_r.send_to_aux;
  assign forward_byte      = res_r.forward_byte;

endmodule
`default_nettype wire

[verif/ps2_keyboard_controller_tb.sv]
// ps2_keyboard_controller_tb: self-checking bench for the 8042-style keyboard controller
// depends on ps2kc_pkg and the ps2_keyboard_controller rtl
`timescale 1ns / 1ps
module ps2_keyboard_controller_tb;
  import ps2kc_pkg::*;

  localparam logic [7:0] RD_RAM_LO = 8'h20;
  localparam logic [7:0] RD_RAM_HI = 8'h3f;
  localparam logic [7:0] WR_RAM_LO = 8'h60;
  localparam logic [7:0] WR_RAM_HI = 8'h7f;
  localparam logic [7:0] PULSE_LO  = 8'hf0;
  localparam logic [7:0] ST_OBF    = 8'h01;
  localparam logic [7:0] ST_CMDPEND = 8'h08;
  localparam logic [7:0] ST_UNLOCK = 8'h10;
  localparam logic [7:0] ST_AUXOBF = 8'h20;
  localparam logic [2:0] ITEM_SPARE6 = 3'd6;
  localparam logic [2:0] ITEM_SPARE7 = 3'd7;

  logic       clk, rst;
  logic       in_valid, in_ready, out_valid, out_ready;
  logic [2:0] command;
  logic [7:0] data_byte;
  result_t    got;

  ps2_keyboard_controller i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .read_value(got.read_value), .device_byte_taken(got.device_byte_taken),
    .irq_keyboard(got.irq_keyboard), .irq_aux(got.irq_aux),
    .a20_update(got.a20_update), .a20_level(got.a20_level),
    .system_reset(got.system_reset), .send_to_keyboard(got.send_to_keyboard),
    .send_to_aux(got.send_to_aux), .forward_byte(got.forward_byte)
  );

  // predictor state
  logic [7:0] kc_ram [RAM_BYTES];
  logic       p_irq_kbd, p_irq_aux, p_a20_upd, p_a20_lvl, p_rst;
  result_t    pending_results[$];

  int errors;
  int rx_gap;
  int hold_cycles;
  int sent_count;
  bit idle_on;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void kc_ram_reset();
    for (int i = 0; i < RAM_BYTES; i++) kc_ram[i] = 8'h00;
    kc_ram[LOC_CMD] = 8'h41;
    kc_ram[LOC_STAT] = 8'h10;
    kc_ram[LOC_OUTPORT] = 8'h03;
  endfunction

  function automatic logic [7:0] set2_to_set1(input logic [7:0] v);
    if (!v[7]) return SC2TO1[v[6:0]];
    if (v == 8'h83) return 8'h41;
    if (v == 8'h84) return 8'h54;
    return v;
  endfunction

  function automatic logic [7:0] translate_key(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (kc_ram[LOC_CMD][6]) begin
      if (v == BYTE_RELEASE) begin
        kc_ram[LOC_RELEASE] = 8'h01;
        return v;
      end
      r = set2_to_set1(v);
      if (kc_ram[LOC_RELEASE] != 0) r = r | 8'h80;
    end
    kc_ram[LOC_RELEASE] = 8'h00;
    return r;
  endfunction

  // 1 when the password lock swallows the byte; may replace it on unlock
  function automatic bit lock_swallows(inout logic [7:0] v, input bit aux);
    logic [7:0] idx;
    if (kc_ram[LOC_STAT] & ST_UNLOCK) return 1'b0;
    if (v[7] || v == kc_ram[LOC_IGN0] || v == kc_ram[LOC_IGN1] || aux) return 1'b1;
    idx = kc_ram[LOC_PWIDX];
    if (v == kc_ram[5'(8 + idx)]) kc_ram[LOC_PWIDX] = idx + 8'd1;
    else kc_ram[LOC_PWIDX] = 8'h00;
    idx = kc_ram[LOC_PWIDX];
    if (idx > 6 || kc_ram[5'(8 + idx)] == 0) begin
      kc_ram[LOC_STAT] = kc_ram[LOC_STAT] | ST_UNLOCK;
      if (kc_ram[LOC_SEC_OFF] != 0) begin
        v = kc_ram[LOC_SEC_OFF];
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void fill_obuf(input logic [7:0] v_in, input bit aux);
    logic [7:0] v, st;
    v = v_in;
    if (lock_swallows(v, aux)) return;
    kc_ram[LOC_OBUF] = v;
    st = (kc_ram[LOC_STAT] & ~(ST_OBF | ST_AUXOBF)) | (aux ? (ST_OBF | ST_AUXOBF) : ST_OBF);
    kc_ram[LOC_STAT] = st;
    if (st[5] && st[0] && kc_ram[LOC_CMD][1]) begin
      kc_ram[LOC_OUTPORT] = kc_ram[LOC_OUTPORT] | 8'h20;
      p_irq_aux = 1'b1;
    end else if (!st[5] && st[0] && kc_ram[LOC_CMD][0]) begin
      kc_ram[LOC_OUTPORT] = kc_ram[LOC_OUTPORT] | 8'h10;
      p_irq_kbd = 1'b1;
    end
  endfunction

  function automatic void show_a20();
    p_a20_upd = 1'b1;
    p_a20_lvl = kc_ram[LOC_OUTPORT][1];
  endfunction

  function automatic result_t predict_word(input logic [2:0] c, input logic [7:0] v);
    result_t r;
    logic [7:0] lc, n, t;
    bit handled, aux;
    r = '0;
    p_irq_kbd = 0; p_irq_aux = 0; p_a20_upd = 0; p_a20_lvl = 0; p_rst = 0;
    case (c)
      ITEM_RD_DATA: begin
        r.read_value = kc_ram[LOC_OBUF];
        kc_ram[LOC_STAT] = kc_ram[LOC_STAT] & ~(ST_OBF | ST_AUXOBF);
        kc_ram[LOC_OUTPORT] = kc_ram[LOC_OUTPORT] & ~8'h30;
      end
      ITEM_RD_STAT:
        r.read_value = (kc_ram[LOC_STAT] & ~8'h04) | (kc_ram[LOC_CMD] & 8'h04);
      ITEM_WR_DATA: if (kc_ram[LOC_STAT] & ST_UNLOCK) begin
        handled = 1'b0;
        if (kc_ram[LOC_STAT] & ST_CMDPEND) begin
          lc = kc_ram[LOC_LASTCMD];
          handled = 1'b1;
          if (lc >= WR_RAM_LO && lc <= WR_RAM_HI) kc_ram[lc[4:0]] = v;
          else if (lc == KC_PW_LOAD) begin
            n = kc_ram[LOC_PWLEN];
            if (n <= 6) begin
              kc_ram[5'(8 + n)] = v;
              kc_ram[LOC_PWLEN] = (v != 0) ? n + 8'd1 : 8'd15;
            end
          end else if (lc == KC_WR_OUTP) begin
            kc_ram[LOC_OUTPORT] = v;
            show_a20();
            if (!v[0]) p_rst = 1'b1;
          end else if (lc == KC_WR_KBDBUF) fill_obuf(translate_key(v), 1'b0);
          else if (lc == KC_WR_AUXBUF) fill_obuf(v, 1'b1);
          else if (lc == KC_WR_AUX) begin
            r.send_to_aux = 1'b1;
            r.forward_byte = v;
          end else if (lc == KC_A20_OFF) begin
            kc_ram[LOC_OUTPORT] = kc_ram[LOC_OUTPORT] & ~8'h02;
            show_a20();
          end else if (lc == KC_A20_ON) begin
            kc_ram[LOC_OUTPORT] = kc_ram[LOC_OUTPORT] | 8'h02;
            show_a20();
          end else handled = 1'b0;
        end
        kc_ram[LOC_STAT] = kc_ram[LOC_STAT] & ~ST_CMDPEND;
        if (!handled) begin
          r.send_to_keyboard = 1'b1;
          r.forward_byte = v;
        end
      end
      ITEM_WR_CMD: if (kc_ram[LOC_STAT] & ST_UNLOCK) begin
        kc_ram[LOC_LASTCMD] = v;
        kc_ram[LOC_STAT] = kc_ram[LOC_STAT] | ST_CMDPEND;
        if (v >= RD_RAM_LO && v <= RD_RAM_HI) fill_obuf(kc_ram[v[4:0]], 1'b0);
        else if (v >= PULSE_LO) begin
          if (!v[0]) p_rst = 1'b1;
        end else case (v)
          KC_PW_CHECK: fill_obuf((kc_ram[LOC_PWLEN] != 0) ? BYTE_ACK : BYTE_NOPW, 1'b0);
          KC_PW_ENABLE: begin
            kc_ram[LOC_STAT] = kc_ram[LOC_STAT] & ~ST_UNLOCK;
            kc_ram[LOC_PWIDX] = 8'h00;
            if (kc_ram[LOC_SEC_ON] != 0) begin
              kc_ram[LOC_OBUF] = kc_ram[LOC_SEC_ON];
              kc_ram[LOC_STAT] = (kc_ram[LOC_STAT] & ~(ST_OBF | ST_AUXOBF)) | ST_OBF;
              if (kc_ram[LOC_CMD][0]) p_irq_kbd = 1'b1;
            end
          end
          KC_AUX_DIS: kc_ram[LOC_CMD] = kc_ram[LOC_CMD] | 8'h20;
          KC_AUX_EN: kc_ram[LOC_CMD] = kc_ram[LOC_CMD] & ~8'h20;
          KC_SELF_TEST: fill_obuf(BYTE_TEST_OK, 1'b0);
          KC_AUX_TEST, KC_KBD_TEST, KC_RD_INPORT, KC_RD_TEST: fill_obuf(8'h00, 1'b0);
          KC_KBD_DIS: kc_ram[LOC_CMD] = kc_ram[LOC_CMD] | 8'h10;
          KC_KBD_EN: kc_ram[LOC_CMD] = kc_ram[LOC_CMD] & ~8'h10;
          KC_RD_OUTP: fill_obuf(kc_ram[LOC_OUTPORT], 1'b0);
          default: ;
        endcase
      end
      ITEM_KBD, ITEM_AUX: begin
        aux = (c == ITEM_AUX);
        if (kc_ram[LOC_DEVLOCK] == 0 && !(aux ? kc_ram[LOC_CMD][5] : kc_ram[LOC_CMD][4])
            && !kc_ram[LOC_STAT][0]) begin
          r.device_byte_taken = 1'b1;
          if (aux) fill_obuf(v, 1'b1);
          else begin
            t = translate_key(v);
            if (kc_ram[LOC_RELEASE] == 0) fill_obuf(t, 1'b0);
          end
        end
      end
      default: ;
    endcase
    r.irq_keyboard = p_irq_kbd;
    r.irq_aux = p_irq_aux;
    r.a20_update = p_a20_upd;
    r.a20_level = p_a20_lvl;
    r.system_reset = p_rst;
    if (p_rst) kc_ram_reset();
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int seen, input int want);
    if (errors < 40) $display("mismatch on %s: got %0h, expected %0h", what, seen, want);
    errors++;
  endtask

  // sends one word; valid stays up between back-to-back words
  task automatic send_word(input logic [2:0] c, input logic [7:0] d);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= c;
    data_byte <= d;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_word(c, d));
  endtask

  // receiver: per-word stall plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", got, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.read_value !== want.read_value)
          report_mismatch("read_value", got.read_value, want.read_value);
        if (got.device_byte_taken !== want.device_byte_taken)
          report_mismatch("device_byte_taken", got.device_byte_taken, want.device_byte_taken);
        if (got.irq_keyboard !== want.irq_keyboard)
          report_mismatch("irq_keyboard", got.irq_keyboard, want.irq_keyboard);
        if (got.irq_aux !== want.irq_aux)
          report_mismatch("irq_aux", got.irq_aux, want.irq_aux);
        if (got.a20_update !== want.a20_update)
          report_mismatch("a20_update", got.a20_update, want.a20_update);
        if (got.a20_level !== want.a20_level)
          report_mismatch("a20_level", got.a20_level, want.a20_level);
        if (got.system_reset !== want.system_reset)
          report_mismatch("system_reset", got.system_reset, want.system_reset);
        if (got.send_to_keyboard !== want.send_to_keyboard)
          report_mismatch("send_to_keyboard", got.send_to_keyboard, want.send_to_keyboard);
        if (got.send_to_aux !== want.send_to_aux)
          report_mismatch("send_to_aux", got.send_to_aux, want.send_to_aux);
        if (got.forward_byte !== want.forward_byte)
          report_mismatch("forward_byte", got.forward_byte, want.forward_byte);
      end
      rx_gap <= idle_on ? $urandom_range(0, 15) : 0;
    end
  end

  task automatic ctrl_cmd(input logic [7:0] c, input logic [7:0] d);
    send_word(ITEM_WR_CMD, c);
    send_word(ITEM_WR_DATA, d);
  endtask

  task automatic test_directed();
    logic [7:0] cmds [17] = '{KC_PW_CHECK, KC_SELF_TEST, KC_AUX_TEST, KC_KBD_TEST,
      KC_RD_INPORT, KC_RD_TEST, KC_RD_OUTP, KC_AUX_DIS, KC_AUX_EN, KC_KBD_DIS, KC_KBD_EN,
      RD_RAM_LO, RD_RAM_HI, 8'h00, 8'hff, 8'hfe, 8'hef};
    idle_on = 1'b0;
    send_word(ITEM_RD_STAT, 8'h00);
    foreach (cmds[i]) begin
      send_word(ITEM_WR_CMD, cmds[i]);
      send_word(ITEM_RD_DATA, 8'hff);
    end
    ctrl_cmd(KC_A20_OFF, 8'h00);
    ctrl_cmd(KC_A20_ON, 8'h00);
    ctrl_cmd(KC_WR_OUTP, 8'h03);
    ctrl_cmd(KC_WR_OUTP, 8'h02);
    ctrl_cmd(KC_WR_AUX, 8'hff);
    ctrl_cmd(KC_WR_KBDBUF, 8'h1c);
    send_word(ITEM_KBD, 8'h00);       // refused, buffer full
    send_word(ITEM_RD_DATA, 8'h00);
    ctrl_cmd(KC_WR_AUXBUF, 8'h80);
    send_word(ITEM_RD_DATA, 8'h00);
    send_word(ITEM_WR_DATA, 8'hee);   // no pending command
    send_word(ITEM_SPARE6, 8'h5a);
    send_word(ITEM_SPARE7, 8'ha5);
    foreach (cmds[i]) if (i < 6) begin
      send_word(ITEM_KBD, (i == 0) ? BYTE_RELEASE : (i == 1) ? 8'h7f : (i == 2) ? 8'h83 :
                (i == 3) ? 8'h84 : (i == 4) ? 8'hff : 8'h00);
      send_word(ITEM_RD_DATA, 8'h00);
    end
    send_word(ITEM_AUX, 8'hff);
    send_word(ITEM_RD_DATA, 8'h00);
  endtask

  // installs a password, locks, types it back with an occasional slip
  task automatic test_password();
    logic [7:0] codes [7];
    int len;
    len = $urandom_range(0, 7);
    ctrl_cmd(WR_RAM_LO, 8'h43 | 8'($urandom_range(0, 3)) << 1);
    ctrl_cmd(WR_RAM_LO | {3'b000, LOC_DEVLOCK}, 8'h00);
    ctrl_cmd(WR_RAM_LO | {3'b000, LOC_IGN0}, 8'h00);
    ctrl_cmd(WR_RAM_LO | {3'b000, LOC_IGN1}, 8'h00);
    ctrl_cmd(WR_RAM_LO | {3'b000, LOC_PWLEN}, 8'h00);
    ctrl_cmd(WR_RAM_LO | {3'b000, LOC_SEC_ON}, ($urandom_range(0, 1)) ? 8'($urandom) : 8'h00);
    ctrl_cmd(WR_RAM_LO | {3'b000, LOC_SEC_OFF}, ($urandom_range(0, 1)) ? 8'($urandom) : 8'h00);
    for (int i = 0; i < len; i++) begin
      do codes[i] = 8'($urandom_range(1, 127)); while (set2_to_set1(codes[i]) >= 8'h80);
      ctrl_cmd(KC_PW_LOAD, set2_to_set1(codes[i]));
    end
    if (len < 7) ctrl_cmd(KC_PW_LOAD, 8'h00);
    send_word(ITEM_RD_DATA, 8'h00);
    send_word(ITEM_WR_CMD, KC_PW_ENABLE);
    send_word(ITEM_RD_DATA, 8'h00);
    send_word(ITEM_WR_CMD, KC_SELF_TEST);  // ignored while locked
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 5) == 0) send_word(ITEM_KBD, 8'($urandom));
      if ($urandom_range(0, 5) == 0) send_word(ITEM_AUX, 8'($urandom));
      send_word(ITEM_KBD, codes[i]);
      send_word(ITEM_RD_DATA, 8'h00);
    end
    send_word(ITEM_KBD, 8'($urandom_range(1, 127)));
    send_word(ITEM_RD_STAT, 8'h00);
    send_word(ITEM_RD_DATA, 8'h00);
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    @(negedge clk);
    hold_cycles = 300;
    repeat (24) send_word(3'($urandom_range(0, 5)), 8'($urandom));
  endtask

  task automatic test_random();
    int kind;
    while (pending_results.size() < 1000 && sent_count < 750) begin
      idle_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      case (kind)
        0: ctrl_cmd(8'($urandom_range(WR_RAM_LO, WR_RAM_HI)), 8'($urandom));
        1, 2: begin
          send_word(ITEM_WR_CMD, 8'($urandom_range(8'h20, 8'hff)));
          send_word(ITEM_WR_DATA, 8'($urandom));
          send_word(ITEM_RD_DATA, 8'h00);
        end
        3, 4: begin
          send_word(ITEM_KBD, ($urandom_range(0, 4) == 0) ? BYTE_RELEASE : 8'($urandom));
          send_word(ITEM_RD_STAT, 8'h00);
          send_word(ITEM_RD_DATA, 8'h00);
        end
        5: begin
          send_word(ITEM_AUX, 8'($urandom));
          send_word(ITEM_RD_DATA, 8'h00);
        end
        6: test_password();
        7: ctrl_cmd(($urandom_range(0, 1)) ? KC_A20_ON : KC_WR_OUTP, 8'($urandom));
        default: send_word(3'($urandom), 8'($urandom));
      endcase
    end
  endtask

  always @(posedge clk) if (in_valid && in_ready) sent_count <= sent_count + 1;

  initial begin
    errors = 0;
    sent_count = 0;
    rx_gap = 0;
    hold_cycles = 0;
    idle_on = 1'b0;
    in_valid = 1'b0;
    command = '0;
    data_byte = '0;
    out_ready = 1'b0;
    rst = 1'b1;
    kc_ram_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_password();
    test_backpressure();
    test_random();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
